FILE: hdl/sgc_pkg.sv
// ---------------------------------------------------------------------------
// Subset graph connectivity package
// Shared widths, command and status codes, and the sequencer microprogram.
// ---------------------------------------------------------------------------
package sgc_pkg;

    localparam int MAX_RELATIONS = 16;
    localparam int SUBSET_W      = 16;
    localparam int IDX_W         = 4;
    localparam int COUNT_W       = 5;
    localparam int PC_W          = 4;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_RELATIONS);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_EDGE  = 2'd1;
    localparam logic [1:0] CMD_CONN  = 2'd2;
    localparam logic [1:0] CMD_CROSS = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SELF  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_FETCH      = 4'd0;
    localparam t_pc PC_CLEAR      = 4'd1;
    localparam t_pc PC_EDGE_CHK   = 4'd2;
    localparam t_pc PC_EDGE_WLO   = 4'd3;
    localparam t_pc PC_EDGE_WHI   = 4'd4;
    localparam t_pc PC_CONN_INIT  = 4'd5;
    localparam t_pc PC_CONN_STEP  = 4'd6;
    localparam t_pc PC_CONN_END   = 4'd7;
    localparam t_pc PC_CROSS_INIT = 4'd8;
    localparam t_pc PC_CROSS_STEP = 4'd9;
    localparam t_pc PC_FINISH     = 4'd10;

    typedef enum logic [3:0] {
        OP_LATCH,
        OP_CLEAR,
        OP_EDGE_CHECK,
        OP_WRITE_LOW,
        OP_WRITE_HIGH,
        OP_CONN_INIT,
        OP_CONN_STEP,
        OP_CONN_RESULT,
        OP_CROSS_INIT,
        OP_CROSS_STEP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DISPATCH,
        JMP_IF_BAD,
        JMP_LOOP,
        JMP_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_FETCH:      w = '{OP_LATCH,       JMP_DISPATCH, PC_FETCH};
            PC_CLEAR:      w = '{OP_CLEAR,       JMP_ALWAYS,   PC_FINISH};
            PC_EDGE_CHK:   w = '{OP_EDGE_CHECK,  JMP_IF_BAD,   PC_FINISH};
            PC_EDGE_WLO:   w = '{OP_WRITE_LOW,   JMP_NEXT,     PC_FETCH};
            PC_EDGE_WHI:   w = '{OP_WRITE_HIGH,  JMP_ALWAYS,   PC_FINISH};
            PC_CONN_INIT:  w = '{OP_CONN_INIT,   JMP_NEXT,     PC_FETCH};
            PC_CONN_STEP:  w = '{OP_CONN_STEP,   JMP_LOOP,     PC_CONN_END};
            PC_CONN_END:   w = '{OP_CONN_RESULT, JMP_ALWAYS,   PC_FINISH};
            PC_CROSS_INIT: w = '{OP_CROSS_INIT,  JMP_NEXT,     PC_FETCH};
            PC_CROSS_STEP: w = '{OP_CROSS_STEP,  JMP_LOOP,     PC_FINISH};
            PC_FINISH:     w = '{OP_EMIT,        JMP_WAIT_OUT, PC_FETCH};
            default:       w = '{OP_LATCH,       JMP_ALWAYS,   PC_FETCH};
        endcase
        return w;
    endfunction

    function automatic t_pc dispatch(input logic [1:0] cmd);
        t_pc pc;
        case (cmd)
            CMD_CLEAR: pc = PC_CLEAR;
            CMD_EDGE:  pc = PC_EDGE_CHK;
            CMD_CONN:  pc = PC_CONN_INIT;
            CMD_CROSS: pc = PC_CROSS_INIT;
            default:   pc = PC_FETCH;
        endcase
        return pc;
    endfunction

    function automatic logic [IDX_W-1:0] lowest_index(input logic [SUBSET_W-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = SUBSET_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: hdl/subset_graph_connectivity.sv
// ---------------------------------------------------------------------------
// Subset graph connectivity
// Join graph neighbor store with edge insertion, connectivity and crossing
// queries, run by a microcoded sequencer over one neighbor row per cycle.
// ---------------------------------------------------------------------------
// One item is worked at a time, and the neighbor store is read at one row per
// cycle, which sets the item time. After fetch, a clear runs clear, finish; an
// edge check, low and high row writes, finish (check, finish if rejected); a
// connectivity query init, a step per relation reached from its lowest member,
// result, finish; a crossing query init, a step per set bit of subset_a, finish.
// The next item is taken while a finished result waits in the output register.
module subset_graph_connectivity
    import sgc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_command,
    input  logic [IDX_W-1:0]    i_edge_left,
    input  logic [IDX_W-1:0]    i_edge_right,
    input  logic [SUBSET_W-1:0] i_subset_a,
    input  logic [SUBSET_W-1:0] i_subset_b,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_connected,
    output logic                o_does_cross,
    output logic [1:0]          o_edge_status,
    output logic                o_graph_usable,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    t_pc                      r_pc, n_pc;
    logic [COUNT_W-1:0]       r_count;
    logic                     r_usable, n_usable;
    logic [MAX_RELATIONS-1:0] r_row_vld;
    logic [SUBSET_W-1:0]      r_rows [MAX_RELATIONS];

    logic [1:0]               r_cmd;
    logic [IDX_W-1:0]         r_left, r_right;
    logic [SUBSET_W-1:0]      r_sa, r_sb, n_sa, n_sb;
    logic [SUBSET_W-1:0]      r_reached, n_reached;
    logic [SUBSET_W-1:0]      r_pending, n_pending;
    logic                     r_conn, n_conn;
    logic                     r_cross, n_cross;
    logic [1:0]               r_status, n_status;

    logic                     r_out_valid;
    logic                     r_o_conn, r_o_cross, r_o_usable;
    logic [1:0]               r_o_status;

    t_uword                   uw;
    logic                     in_acc;
    logic                     out_free;
    logic [COUNT_W-1:0]       count_cap;
    logic [IDX_W-1:0]         idx_low, idx_high, scan_idx, rd_addr;
    logic [SUBSET_W-1:0]      rd_row, scan_bit, adj;
    logic [1:0]               chk_status;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [SUBSET_W-1:0]      wr_data;
    logic                     clr_rows;

    assign uw       = ucode(r_pc);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign count_cap = (r_count > COUNT_W'(MAX_RELATIONS)) ? COUNT_W'(MAX_RELATIONS) : r_count;
    assign idx_low   = (r_left < r_right) ? r_left : r_right;
    assign idx_high  = (r_left < r_right) ? r_right : r_left;
    assign scan_idx  = lowest_index(r_pending);
    assign scan_bit  = r_pending & (~r_pending + SUBSET_W'(1));

    always_comb begin
        case (uw.op)
            OP_EDGE_CHECK, OP_WRITE_LOW: rd_addr = idx_low;
            OP_WRITE_HIGH:               rd_addr = idx_high;
            default:                     rd_addr = scan_idx;
        endcase
    end

    assign rd_row = r_row_vld[rd_addr] ? r_rows[rd_addr] : '0;
    assign adj    = rd_row & r_sa;

    always_comb begin
        if (r_left == r_right) begin
            chk_status = ST_SELF;
        end else if ({1'b0, r_left} >= count_cap || {1'b0, r_right} >= count_cap) begin
            chk_status = ST_RANGE;
        end else if (rd_row[idx_high]) begin
            chk_status = ST_DUP;
        end else begin
            chk_status = ST_OK;
        end
    end

    always_comb begin
        n_pc      = r_pc;
        n_usable  = r_usable;
        n_sa      = r_sa;
        n_sb      = r_sb;
        n_reached = r_reached;
        n_pending = r_pending;
        n_conn    = r_conn;
        n_cross   = r_cross;
        n_status  = r_status;
        wr_en     = 1'b0;
        wr_addr   = rd_addr;
        wr_data   = rd_row;
        clr_rows  = 1'b0;

        case (uw.op)
            OP_LATCH: begin
                n_sa     = i_subset_a;
                n_sb     = i_subset_b;
                n_conn   = 1'b0;
                n_cross  = 1'b0;
                n_status = ST_OK;
            end
            OP_CLEAR: begin
                clr_rows = 1'b1;
                n_usable = 1'b1;
            end
            OP_EDGE_CHECK: begin
                n_status = chk_status;
                if (chk_status != ST_OK) begin
                    n_usable = 1'b0;
                end
            end
            OP_WRITE_LOW: begin
                wr_en   = 1'b1;
                wr_data = rd_row | (SUBSET_W'(1) << idx_high);
            end
            OP_WRITE_HIGH: begin
                wr_en   = 1'b1;
                wr_data = rd_row | (SUBSET_W'(1) << idx_low);
            end
            OP_CONN_INIT: begin
                n_reached = r_sa & (~r_sa + SUBSET_W'(1));
                n_pending = r_sa & (~r_sa + SUBSET_W'(1));
            end
            OP_CONN_STEP: begin
                if (r_pending != '0) begin
                    n_reached = r_reached | adj;
                    n_pending = (r_pending & ~scan_bit) | (adj & ~r_reached);
                end
            end
            OP_CONN_RESULT: begin
                n_conn = (r_sa != '0) && (r_reached == r_sa);
            end
            OP_CROSS_INIT: begin
                n_pending = r_sa;
            end
            OP_CROSS_STEP: begin
                if (r_pending != '0) begin
                    n_pending = r_pending & ~scan_bit;
                    if ((rd_row & r_sb) != '0) begin
                        n_cross = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        case (uw.cond)
            JMP_NEXT:     n_pc = r_pc + t_pc'(1);
            JMP_ALWAYS:   n_pc = uw.target;
            JMP_DISPATCH: n_pc = in_acc ? dispatch(i_command) : r_pc;
            JMP_IF_BAD:   n_pc = (chk_status != ST_OK) ? uw.target : r_pc + t_pc'(1);
            JMP_LOOP:     n_pc = (r_pending != '0) ? r_pc : uw.target;
            JMP_WAIT_OUT: n_pc = out_free ? uw.target : r_pc;
            default:      n_pc = PC_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_FETCH;
            r_count     <= COUNT_RESET;
            r_usable    <= 1'b1;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_usable <= n_usable;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (clr_rows) begin
                r_row_vld <= '0;
            end else if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (uw.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rows[wr_addr] <= wr_data;
        end
        if (in_acc) begin
            r_cmd   <= i_command;
            r_left  <= i_edge_left;
            r_right <= i_edge_right;
        end
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_reached <= n_reached;
        r_pending <= n_pending;
        r_conn    <= n_conn;
        r_cross   <= n_cross;
        r_status  <= n_status;
        if (uw.op == OP_EMIT && out_free) begin
            r_o_conn   <= (r_cmd == CMD_CONN) && r_conn;
            r_o_cross  <= (r_cmd == CMD_CROSS) && r_cross;
            r_o_status <= (r_cmd == CMD_EDGE) ? r_status : ST_OK;
            r_o_usable <= r_usable;
        end
    end

    assign o_in_stall     = (r_pc != PC_FETCH);
    assign o_out_valid    = r_out_valid;
    assign o_is_connected = r_o_conn;
    assign o_does_cross   = r_o_cross;
    assign o_edge_status  = r_o_status;
    assign o_graph_usable = r_o_usable;
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: hdl/sgc_checker.sv
// ---------------------------------------------------------------------------
// Subset graph connectivity checker
// Port-level properties of the connectivity block, bound to the top level.
// ---------------------------------------------------------------------------
module sgc_checker
    import sgc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_is_connected,
    input logic       o_does_cross,
    input logic [1:0] o_edge_status,
    input logic       o_graph_usable
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Output item dropped while stalled.");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_connected |-> !o_does_cross && o_edge_status == ST_OK)
        else $error("Result carries answers of more than one command.");

    a_err_unusable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_edge_status != ST_OK |-> !o_graph_usable)
        else $error("Edge error reported while the graph stays usable.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("A second item was offered acceptance right after the first.");

endmodule

bind subset_graph_connectivity sgc_checker u_sgc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_is_connected (o_is_connected),
    .o_does_cross   (o_does_cross),
    .o_edge_status  (o_edge_status),
    .o_graph_usable (o_graph_usable)
);
